// ----- design/bar_pkg.sv -----
// Package for the button auto-repeat core: pad bit masks and CSR address codes.
// Used by button_auto_repeat_core and the testbench; depends on nothing else.

package bar_pkg;

   // Pad layout masks
   localparam logic [15:0] BTN_UP     = 16'h0010;
   localparam logic [15:0] BTN_RIGHT  = 16'h0020;
   localparam logic [15:0] BTN_DOWN   = 16'h0040;
   localparam logic [15:0] BTN_LEFT   = 16'h0080;
   localparam logic [15:0] BTN_L1     = 16'h0400;
   localparam logic [15:0] BTN_R1     = 16'h0800;

   localparam int unsigned BTN_SQUARE_BIT = 15;

   localparam logic [15:0] REPEATABLE_MASK =
      BTN_L1 | BTN_R1 | BTN_UP | BTN_RIGHT | BTN_DOWN | BTN_LEFT;
   localparam logic [15:0] DIRECTION_MASK  = BTN_UP | BTN_RIGHT | BTN_DOWN | BTN_LEFT;

   // Repeat groups with and without the modifier held
   localparam logic [15:0] DIR_MOD_MASK    = BTN_RIGHT | BTN_LEFT;
   localparam logic [15:0] SHOULDER_MASK   = BTN_L1 | BTN_R1;
   localparam logic [15:0] SHLD_MOD_MASK   = BTN_L1 | BTN_R1 | BTN_UP | BTN_DOWN;

   localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

   // CSR word index (byte address bits [3:2])
   typedef enum logic [1:0] {
      CSR_INITIAL_DELAY    = 2'd0,
      CSR_REPEAT_PERIOD    = 2'd1,
      CSR_SECONDARY_PERIOD = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   // Saturating increment of a 16-bit counter
   function automatic logic [15:0] sat_inc(input logic [15:0] value);
      logic [15:0] result;
      if (value == COUNT_MAX) begin
         result = COUNT_MAX;
      end else begin
         result = value + 16'd1;
      end
      return result;
   endfunction

endpackage

// ----- design/button_auto_repeat_core.sv -----
// Button auto-repeat core: one pad sample in, one event mask out per transfer.
// Depends on bar_pkg (masks, CSR codes, saturating increment).
//
//  channel   dir   handshake              payload
//  req_      in    tvalid/tready          tdata[15:0] = pad_buttons
//  rsp_      out   tvalid/tready          tdata[15:0] = event_mask
//  csr_      in    psel/penable/pready    paddr[3:0], pwdata/prdata 32 bits
//
// One sample per cycle while req_tready is high. The counter update and event
// decode sit between the state registers and the output register, so a result
// is registered from its input transfer. A two-entry output stage (result
// register plus skid register) keeps input transfers going while a result
// waits; req_tready drops only when both entries hold. Reset is synchronous and
// clears the state, counters, configuration and valid flags, not the output data.

module button_auto_repeat_core
   import bar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] pad_buttons
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] event_mask
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers
   logic [15:0] initial_delay_ff;
   logic [15:0] repeat_period_ff;
   logic [15:0] secondary_period_ff;

   // Frame state
   logic [15:0] last_buttons_ff,    last_buttons_in;
   logic [15:0] hold_count_ff,      hold_count_in;
   logic [15:0] repeat_count_ff,    repeat_count_in;
   logic [15:0] secondary_count_ff, secondary_count_in;

   // Output stage
   logic        out_valid_ff,  out_valid_in;
   logic [15:0] out_data_ff,   out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [15:0] skid_data_ff,  skid_data_in;

   logic          req_xfer;
   logic          rsp_xfer;
   logic          csr_write;
   csr_index_type csr_index;
   logic [15:0]   event_mask;

   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         CSR_INITIAL_DELAY:    csr_prdata = {16'd0, initial_delay_ff};
         CSR_REPEAT_PERIOD:    csr_prdata = {16'd0, repeat_period_ff};
         CSR_SECONDARY_PERIOD: csr_prdata = {16'd0, secondary_period_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_delay_ff    <= '0;
         repeat_period_ff    <= '0;
         secondary_period_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INITIAL_DELAY:    initial_delay_ff    <= csr_pwdata[15:0];
            CSR_REPEAT_PERIOD:    repeat_period_ff    <= csr_pwdata[15:0];
            CSR_SECONDARY_PERIOD: secondary_period_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Per-sample counter update and event decode
   always_comb begin
      logic [15:0] now;
      logic [15:0] held;
      logic        square;
      logic [15:0] hold_base;
      logic [15:0] rep_base;
      logic [15:0] sec_base;
      logic [15:0] hold_next;
      logic [15:0] rep_next;
      logic [15:0] sec_next;
      logic        init_fire;

      now    = req_tdata;
      held   = now & REPEATABLE_MASK;
      square = now[BTN_SQUARE_BIT];

      // all released clears the counters first
      if (now == 16'd0) begin
         hold_base = '0;
         rep_base  = '0;
         sec_base  = '0;
      end else begin
         hold_base = hold_count_ff;
         rep_base  = repeat_count_ff;
         sec_base  = secondary_count_ff;
      end

      hold_next = sat_inc(hold_base);
      rep_next  = sat_inc(rep_base);
      sec_next  = sat_inc(sec_base);
      init_fire = (hold_next != hold_base) && (hold_next == initial_delay_ff);

      last_buttons_in    = now;
      hold_count_in      = hold_base;
      repeat_count_in    = rep_base;
      secondary_count_in = sec_base;
      event_mask         = '0;

      if ((last_buttons_ff != now) || (held == 16'd0)) begin
         // changed or nothing repeatable: newly pressed bits only
         event_mask    = ~last_buttons_ff & now;
         hold_count_in = '0;
      end else begin
         hold_count_in = hold_next;
         if (init_fire) begin
            event_mask = held;
         end
         if (hold_next >= initial_delay_ff) begin
            repeat_count_in    = rep_next;
            secondary_count_in = sec_next;
            if (rep_next >= repeat_period_ff) begin
               repeat_count_in = '0;
               event_mask      = now & (square ? DIR_MOD_MASK : DIRECTION_MASK);
            end
            if (sec_next >= secondary_period_ff) begin
               secondary_count_in = '0;
               event_mask = event_mask | (now & (square ? SHLD_MOD_MASK : SHOULDER_MASK));
            end
         end else begin
            repeat_count_in    = '0;
            secondary_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_buttons_ff    <= '0;
         hold_count_ff      <= '0;
         repeat_count_ff    <= '0;
         secondary_count_ff <= '0;
      end else if (req_xfer) begin
         last_buttons_ff    <= last_buttons_in;
         hold_count_ff      <= hold_count_in;
         repeat_count_ff    <= repeat_count_in;
         secondary_count_ff <= secondary_count_in;
      end
   end

   // Output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_xfer) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_xfer) begin
         if (!out_valid_ff || rsp_xfer) begin
            out_valid_in = 1'b1;
            out_data_in  = event_mask;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = event_mask;
         end
      end else if (rsp_xfer) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_released_clears: assert property (@(posedge clock) disable iff (reset)
      (last_buttons_ff == 16'd0) |-> (hold_count_ff == 16'd0 && repeat_count_ff == 16'd0
                                      && secondary_count_ff == 16'd0))
      else $error("counters not cleared after all-released sample");

   a_hold_needs_repeatable: assert property (@(posedge clock) disable iff (reset)
      (hold_count_ff != 16'd0) |-> ((last_buttons_ff & REPEATABLE_MASK) != 16'd0))
      else $error("hold count running without a repeatable button");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !out_valid_ff) |=> (out_valid_ff && !skid_valid_ff))
      else $error("accepted sample did not reach the output register");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for button_auto_repeat_core: drives pad samples on the
// req_ stream, programs timing over the csr_ port and checks every event mask.
// Depends on bar_pkg for pad masks and CSR index codes.

module tb;
   import bar_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 50_000;
   localparam int unsigned RANDOM_ITEMS = 1350;
   localparam int unsigned IDLE_PCT     = 18;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] pad_buttons
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [15:0] event_mask
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   button_auto_repeat_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor copy of the timing registers and the repeat state
   logic [15:0] cfg_delay     = '0;
   logic [15:0] cfg_period    = '0;
   logic [15:0] cfg_secondary = '0;
   logic [15:0] pad_last      = '0;
   logic [15:0] hold_cnt      = '0;
   logic [15:0] rep_cnt       = '0;
   logic [15:0] sec_cnt       = '0;

   logic [15:0] expected_events[$];
   int unsigned error_count    = 0;
   int unsigned samples_sent   = 0;
   int unsigned masks_checked  = 0;
   int unsigned nonzero_masks  = 0;
   int unsigned cycle_count    = 0;
   bit          idle_on        = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t tb: timeout after %0d cycles, %0d masks outstanding", $time,
                  cycle_count, expected_events.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   // Result side backpressure
   always @(posedge clock) begin
      if (idle_on) begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [15:0] count_up(input logic [15:0] value);
      return (value == 16'hFFFF) ? value : value + 16'd1;
   endfunction

   // Expected event mask for one sample; advances the predictor state
   function automatic logic [15:0] predict_event(input logic [15:0] now);
      logic [15:0] prev;
      logic [15:0] held;
      logic [15:0] ev;
      logic [15:0] old_hold;
      logic        square_held;
      prev        = pad_last;
      held        = now & REPEATABLE_MASK;
      square_held = now[BTN_SQUARE_BIT];
      ev          = '0;
      // all released clears the counters first
      if (now == 16'h0000) begin
         hold_cnt = '0;
         rep_cnt  = '0;
         sec_cnt  = '0;
      end
      pad_last = now;
      if (prev != now || held == 16'h0000) begin
         ev       = ~prev & now;
         hold_cnt = '0;
      end else begin
         old_hold = hold_cnt;
         hold_cnt = count_up(old_hold);
         // initial event only when the count steps onto the delay
         if (hold_cnt != old_hold && hold_cnt == cfg_delay) ev = held;
         if (hold_cnt >= cfg_delay) begin
            rep_cnt = count_up(rep_cnt);
            sec_cnt = count_up(sec_cnt);
            if (rep_cnt >= cfg_period) begin
               rep_cnt = '0;
               ev = now & (square_held ? DIR_MOD_MASK : DIRECTION_MASK);
            end
            if (sec_cnt >= cfg_secondary) begin
               sec_cnt = '0;
               ev |= now & (square_held ? SHLD_MOD_MASK : SHOULDER_MASK);
            end
         end else begin
            rep_cnt = '0;
            sec_cnt = '0;
         end
      end
      return ev;
   endfunction

   // Check each result transfer, then predict from each input transfer
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $display("%0t tb: unexpected event mask, expected none, actual %04h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_events.pop_front();
               masks_checked++;
               if (rsp_tdata !== want) begin
                  $display("%0t tb: event_mask mismatch, expected %04h, actual %04h",
                           $time, want, rsp_tdata);
                  error_count++;
               end
               if (want != 16'h0000) nonzero_masks++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_events.push_back(predict_event(req_tdata));
         end
      end
   end

   // One pad sample on the input stream, with optional idle gaps first
   task automatic send_sample(input logic [15:0] pad);
      if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pad;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   task automatic hold_sample(input logic [15:0] pad, input int unsigned frames);
      repeat (frames) send_sample(pad);
   endtask

   // Stop sending and wait until every expected mask has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write: setup then access phase
   task automatic csr_write(input csr_index_type idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_INITIAL_DELAY:    cfg_delay     = value;
         CSR_REPEAT_PERIOD:    cfg_period    = value;
         CSR_SECONDARY_PERIOD: cfg_secondary = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [15:0] delay, input logic [15:0] period,
                             input logic [15:0] secondary);
      csr_write(CSR_INITIAL_DELAY, delay);
      csr_write(CSR_REPEAT_PERIOD, period);
      csr_write(CSR_SECONDARY_PERIOD, secondary);
   endtask

   // Registers at reset are zero: repeats on every held frame, no initial event
   task automatic test_reset_timing();
      hold_sample(BTN_UP, 3);
      hold_sample(BTN_L1 | BTN_R1, 2);
      send_sample(16'h0000);
      wait_drained();
   endtask

   // Press/release extremes, delay and repeat, modifier, non-repeatable hold
   task automatic test_directed_cases();
      set_timing(16'd3, 16'd2, 16'd3);
      csr_write(CSR_UNUSED, 16'hFFFF);    // no register there
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      hold_sample(BTN_L1 | BTN_R1 | BTN_UP | BTN_RIGHT, 6);
      hold_sample(16'h8000 | DIRECTION_MASK | SHOULDER_MASK, 6);
      hold_sample(16'h1009, 3);
      send_sample(16'h0000);
      wait_drained();
   endtask

   function automatic logic [15:0] random_pad();
      int unsigned pick;
      logic [15:0] pad;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         pad = 16'h0000;
      end else if (pick < 35) begin
         pad = 16'($urandom);
      end else begin
         // mostly repeatable buttons, sometimes the modifier, few others
         pad = 16'($urandom) & REPEATABLE_MASK;
         if (pad == 16'h0000) pad = BTN_RIGHT;
         if ($urandom_range(0, 2) == 0) pad[BTN_SQUARE_BIT] = 1'b1;
         if ($urandom_range(0, 4) == 0) pad |= 16'($urandom) & ~REPEATABLE_MASK;
      end
      return pad;
   endfunction

   // Random holds and presses over several timing settings
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned sent;
      int unsigned span;
      int unsigned frames;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       set_timing(16'd0, 16'd0, 16'd0);
            1:       set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
            2:       set_timing(16'd1, 16'd1, 16'd2);
            default: set_timing(16'($urandom_range(0, 8)), 16'($urandom_range(0, 6)),
                                16'($urandom_range(0, 9)));
         endcase
         // one phase runs without any idling
         idle_on = (phase != 3);
         span    = (phase == 1) ? 30 : 24;
         sent    = 0;
         while (sent < RANDOM_ITEMS / 8) begin
            if ($urandom_range(0, 9) == 0) begin
               frames = 1;
               send_sample(16'($urandom));
            end else begin
               frames = $urandom_range(1, span);
               hold_sample(random_pad(), frames);
            end
            sent += frames;
         end
         wait_drained();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      test_reset_timing();
      test_directed_cases();
      test_random_traffic();

      wait_drained();
      $display("tb: %0d pad samples sent, %0d event masks checked, %0d of them nonzero",
               samples_sent, masks_checked, nonzero_masks);
      $display("tb: covered reset, zero and maximum timing, modifier and random holds");
      if (error_count == 0 && expected_events.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- button_auto_repeat_core.f -----
design/bar_pkg.sv
design/button_auto_repeat_core.sv
test/tb.sv
